// ----- rtl/jsu_pkg.sv -----
`default_nettype none
package jsu_pkg;

  localparam int MAX_RES    = 6;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // result kinds
  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_DONE = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  // error codes
  localparam logic [2:0] ERR_NO_QUOTE = 3'd0;
  localparam logic [2:0] ERR_TRUNC    = 3'd1;
  localparam logic [2:0] ERR_BAD_HEX  = 3'd2;
  localparam logic [2:0] ERR_UNKNOWN  = 3'd3;
  localparam logic [2:0] ERR_UNTERM   = 3'd4;

  // top six bits of a high surrogate (0xD800..0xDBFF)
  localparam logic [5:0] HI_SURR_TAG = 6'b110110;

  typedef enum logic [1:0] {
    MAIN_NONE,
    MAIN_RAW,
    MAIN_CP
  } main_sel_t;

  typedef enum logic [1:0] {
    TAIL_NONE,
    TAIL_DONE,
    TAIL_ERR
  } tail_sel_t;

  // At most one command per byte: [pending high surrogate] [main item] [done/error]
  typedef struct packed {
    logic        hi_en;
    logic [9:0]  hi_low;
    main_sel_t   main_sel;
    logic [20:0] main_val;
    tail_sel_t   tail_sel;
    logic [2:0]  err;
  } cmd_t;

endpackage
`default_nettype wire

// ----- rtl/json_string_unescape_utf8.sv -----
// JSON string unescaper with UTF-8 output.
// Input channel (in_valid/in_ready): one byte of text per transaction, starting
// at the opening quote; in_last_of_text marks the final byte of the text.
// Output channel (out_valid/out_ready): one result per transaction: a data
// byte, a done marker or an error code; out_last flags the final result that
// one input byte caused. Bytes that cause no result (opening quote, backslash,
// hex digits mid-escape) produce no output transaction.
// The first result of a byte passes through the command queue and the output register.
// Throughput: one byte per cycle while each byte yields at most one result
// and the receiver takes every result. A byte that yields n results (up to
// five, e.g. a flushed high surrogate, a data byte and an error) holds the
// output until all n are taken; a four-entry command queue between the parser
// and the serializer keeps taking bytes meanwhile, so in_ready drops only once
// that queue fills. When the receiver stalls, the output register holds its
// result and the queue fills; in_ready goes low when it is full.
// Reset (rst_n low, synchronous) empties the queue, drops out_valid and puts
// the parser back to waiting for an opening quote.
`default_nettype none
module json_string_unescape_utf8 (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  output logic       in_ready,
  input  wire [7:0]  in_byte,
  input  wire        in_last_of_text,
  output logic       out_valid,
  input  wire        out_ready,
  output logic [7:0] out_byte,
  output logic [1:0] out_kind,
  output logic [2:0] out_error_code,
  output logic       out_last
);
  import jsu_pkg::*;

  cmd_t push_cmd, head;
  logic push, pop, full, empty;

  jsu_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_byte         (in_byte),
    .in_last_of_text (in_last_of_text),
    .q_full          (full),
    .q_push          (push),
    .q_cmd           (push_cmd)
  );

  jsu_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .full     (full),
    .empty    (empty)
  );

  jsu_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (empty),
    .head           (head),
    .q_pop          (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_kind       (out_kind),
    .out_error_code (out_error_code),
    .out_last       (out_last)
  );

endmodule
`default_nettype wire

// ----- rtl/jsu_front.sv -----
`default_nettype none
module jsu_front (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_ready,
  input  wire [7:0]         in_byte,
  input  wire               in_last_of_text,
  input  wire               q_full,
  output logic              q_push,
  output jsu_pkg::cmd_t     q_cmd
);
  import jsu_pkg::*;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_U      = 8'h75;

  typedef enum logic [2:0] {
    M_IDLE,
    M_STR,
    M_ESC,
    M_HEX,
    M_AFTER_HIGH,
    M_HIGH_BS,
    M_HIGH_U
  } mode_t;

  mode_t       mode_r, mode_nxt;
  logic [15:0] acc_r, acc_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [9:0]  ph_r, ph_nxt;
  logic        accept;
  cmd_t        cmd;

  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
    return r;
  endfunction

  // {known, decoded byte} of a short escape
  function automatic logic [8:0] esc_map(input logic [7:0] c);
    logic [8:0] r;
    r = '0;
    unique case (c)
      8'h22:   r = {1'b1, 8'h22};
      8'h5C:   r = {1'b1, 8'h5C};
      8'h2F:   r = {1'b1, 8'h2F};
      8'h62:   r = {1'b1, 8'h08};
      8'h66:   r = {1'b1, 8'h0C};
      8'h6E:   r = {1'b1, 8'h0A};
      8'h72:   r = {1'b1, 8'h0D};
      8'h74:   r = {1'b1, 8'h09};
      default: r = '0;
    endcase
    return r;
  endfunction

  assign in_ready = !q_full;
  assign accept   = in_valid && !q_full;
  assign q_cmd    = cmd;
  assign q_push   = accept && (cmd.hi_en || cmd.main_sel != MAIN_NONE ||
                               cmd.tail_sel != TAIL_NONE);

  always_comb begin
    logic        do_str, do_esc, do_chk, last;
    logic [4:0]  hv;
    logic [8:0]  em;
    logic [15:0] acc_v;
    logic [2:0]  cnt_v;
    last     = in_last_of_text;
    hv       = hex_val(in_byte);
    em       = esc_map(in_byte);
    acc_v    = {acc_r[11:0], hv[3:0]};
    cnt_v    = cnt_r + 3'd1;
    do_str   = 1'b0;
    do_esc   = 1'b0;
    do_chk   = 1'b0;
    mode_nxt = mode_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    ph_nxt   = ph_r;
    cmd      = '0;
    // the high surrogate leaving with this byte is normally the one held so far
    cmd.hi_low = ph_r;

    unique case (mode_r)
      M_STR: do_str = 1'b1;
      M_ESC: do_esc = 1'b1;
      M_HEX: begin
        if (!hv[4]) begin
          cmd.tail_sel = TAIL_ERR;
          cmd.err      = ERR_BAD_HEX;
          mode_nxt     = M_IDLE;
        end else begin
          acc_nxt = acc_v;
          cnt_nxt = cnt_v;
          do_chk  = 1'b1;
        end
      end
      M_AFTER_HIGH: begin
        if (in_byte == CH_BSLASH && !last) begin
          mode_nxt = M_HIGH_BS;
        end else begin
          cmd.hi_en = 1'b1;
          do_str    = 1'b1;
        end
      end
      M_HIGH_BS: begin
        if (in_byte == CH_U && !last) begin
          mode_nxt = M_HIGH_U;
          acc_nxt  = '0;
          cnt_nxt  = '0;
        end else begin
          cmd.hi_en = 1'b1;
          do_esc    = 1'b1;
        end
      end
      M_HIGH_U: begin
        if (!hv[4]) begin
          cmd.hi_en    = 1'b1;
          cmd.tail_sel = TAIL_ERR;
          cmd.err      = ERR_BAD_HEX;
          mode_nxt     = M_IDLE;
        end else begin
          acc_nxt = acc_v;
          cnt_nxt = cnt_v;
          // not a low surrogate: flush the high one and decode as a plain \u
          if ((cnt_v == 3'd1 && hv[3:0] != 4'hD) || (cnt_v == 3'd2 && hv[3:0] < 4'hC)) begin
            cmd.hi_en = 1'b1;
            mode_nxt  = M_HEX;
            do_chk    = 1'b1;
          end else if (cnt_v >= 3'd4) begin
            cmd.main_sel = MAIN_CP;
            cmd.main_val = 21'({ph_r, acc_v[9:0]}) + 21'h10000;
            mode_nxt     = M_STR;
            if (last) begin
              cmd.tail_sel = TAIL_ERR;
              cmd.err      = ERR_UNTERM;
              mode_nxt     = M_IDLE;
            end
          end else if (last) begin
            cmd.hi_en    = 1'b1;
            cmd.tail_sel = TAIL_ERR;
            cmd.err      = ERR_BAD_HEX;
            mode_nxt     = M_IDLE;
          end
        end
      end
      default: begin
        if (in_byte == CH_QUOTE) begin
          mode_nxt = M_STR;
          if (last) begin
            cmd.tail_sel = TAIL_ERR;
            cmd.err      = ERR_UNTERM;
            mode_nxt     = M_IDLE;
          end
        end else begin
          cmd.tail_sel = TAIL_ERR;
          cmd.err      = ERR_NO_QUOTE;
          mode_nxt     = M_IDLE;
        end
      end
    endcase

    if (do_str) begin
      mode_nxt = M_STR;
      if (in_byte == CH_QUOTE) begin
        cmd.tail_sel = TAIL_DONE;
        mode_nxt     = M_IDLE;
      end else if (in_byte == CH_BSLASH) begin
        if (last) begin
          cmd.tail_sel = TAIL_ERR;
          cmd.err      = ERR_TRUNC;
          mode_nxt     = M_IDLE;
        end else begin
          mode_nxt = M_ESC;
        end
      end else begin
        cmd.main_sel = MAIN_RAW;
        cmd.main_val = {13'd0, in_byte};
        if (last) begin
          cmd.tail_sel = TAIL_ERR;
          cmd.err      = ERR_UNTERM;
          mode_nxt     = M_IDLE;
        end
      end
    end

    if (do_esc) begin
      if (em[8]) begin
        cmd.main_sel = MAIN_RAW;
        cmd.main_val = {13'd0, em[7:0]};
        mode_nxt     = M_STR;
        if (last) begin
          cmd.tail_sel = TAIL_ERR;
          cmd.err      = ERR_UNTERM;
          mode_nxt     = M_IDLE;
        end
      end else if (in_byte == CH_U) begin
        if (last) begin
          cmd.tail_sel = TAIL_ERR;
          cmd.err      = ERR_BAD_HEX;
          mode_nxt     = M_IDLE;
        end else begin
          mode_nxt = M_HEX;
          acc_nxt  = '0;
          cnt_nxt  = '0;
        end
      end else begin
        cmd.tail_sel = TAIL_ERR;
        cmd.err      = ERR_UNKNOWN;
        mode_nxt     = M_IDLE;
      end
    end

    if (do_chk) begin
      if (cnt_v >= 3'd4) begin
        if (acc_v[15:10] == HI_SURR_TAG) begin
          ph_nxt   = acc_v[9:0];
          mode_nxt = M_AFTER_HIGH;
          if (last) begin
            // text ends right after a high surrogate: emit this one alone
            cmd.hi_en    = 1'b1;
            cmd.hi_low   = acc_v[9:0];
            cmd.tail_sel = TAIL_ERR;
            cmd.err      = ERR_UNTERM;
            mode_nxt     = M_IDLE;
          end
        end else begin
          cmd.main_sel = MAIN_CP;
          cmd.main_val = {5'd0, acc_v};
          mode_nxt     = M_STR;
          if (last) begin
            cmd.tail_sel = TAIL_ERR;
            cmd.err      = ERR_UNTERM;
            mode_nxt     = M_IDLE;
          end
        end
      end else if (last) begin
        cmd.tail_sel = TAIL_ERR;
        cmd.err      = ERR_BAD_HEX;
        mode_nxt     = M_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      acc_r  <= '0;
      cnt_r  <= '0;
      ph_r   <= '0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      acc_r  <= acc_nxt;
      cnt_r  <= cnt_nxt;
      ph_r   <= ph_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/jsu_fifo.sv -----
`default_nettype none
module jsu_fifo (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  push,
  input  jsu_pkg::cmd_t        push_cmd,
  input  wire                  pop,
  output jsu_pkg::cmd_t        head,
  output logic                 full,
  output logic                 empty
);
  import jsu_pkg::*;

  cmd_t                 mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_r, rd_r;
  logic [FIFO_AW:0]     cnt_r;
  logic                 do_push, do_pop;

  assign full    = (cnt_r == (FIFO_AW+1)'(FIFO_DEPTH));
  assign empty   = (cnt_r == '0);
  assign head    = mem_r[rd_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wr_r <= FIFO_AW'(wr_r + 1'b1);
      if (do_pop) rd_r <= FIFO_AW'(rd_r + 1'b1);
      if (do_push && !do_pop) cnt_r <= cnt_r + 1'b1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_r] <= push_cmd;
  end

endmodule
`default_nettype wire

// ----- rtl/jsu_back.sv -----
`default_nettype none
module jsu_back (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               q_empty,
  input  jsu_pkg::cmd_t     head,
  output logic              q_pop,
  output logic              out_valid,
  input  wire               out_ready,
  output logic [7:0]        out_byte,
  output logic [1:0]        out_kind,
  output logic [2:0]        out_error_code,
  output logic              out_last
);
  import jsu_pkg::*;

  typedef struct packed {
    logic [2:0]      len;
    logic [3:0][7:0] b;
  } utf8_t;

  function automatic utf8_t utf8_enc(input logic [20:0] cp);
    utf8_t r;
    r = '0;
    if (cp < 21'h80) begin
      r.len  = 3'd1;
      r.b[0] = cp[7:0];
    end else if (cp < 21'h800) begin
      r.len  = 3'd2;
      r.b[0] = {3'b110, cp[10:6]};
      r.b[1] = {2'b10, cp[5:0]};
    end else if (cp < 21'h10000) begin
      r.len  = 3'd3;
      r.b[0] = {4'b1110, cp[15:12]};
      r.b[1] = {2'b10, cp[11:6]};
      r.b[2] = {2'b10, cp[5:0]};
    end else begin
      r.len  = 3'd4;
      r.b[0] = {5'b11110, cp[20:18]};
      r.b[1] = {2'b10, cp[17:12]};
      r.b[2] = {2'b10, cp[11:6]};
      r.b[3] = {2'b10, cp[5:0]};
    end
    return r;
  endfunction

  logic [7:0] lst_byte [MAX_RES];
  logic [1:0] lst_kind [MAX_RES];
  logic [2:0] lst_err  [MAX_RES];
  logic [2:0] n;

  logic       out_valid_r, out_valid_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic [1:0] kind_r, kind_nxt;
  logic [2:0] err_r, err_nxt;
  logic       last_r, last_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic       out_free, last_ent;

  // expand the head command into its list of results
  always_comb begin
    utf8_t      hi_e, mn_e;
    logic [2:0] k;
    hi_e = utf8_enc({5'd0, HI_SURR_TAG, head.hi_low});
    if (head.main_sel == MAIN_RAW) begin
      mn_e      = '0;
      mn_e.len  = 3'd1;
      mn_e.b[0] = head.main_val[7:0];
    end else begin
      mn_e = utf8_enc(head.main_val);
    end
    for (int i = 0; i < MAX_RES; i++) begin
      lst_byte[i] = '0;
      lst_kind[i] = KIND_DATA;
      lst_err[i]  = '0;
    end
    k = '0;
    if (head.hi_en) begin
      for (int i = 0; i < 3; i++) begin
        lst_byte[k] = hi_e.b[i];
        k = k + 3'd1;
      end
    end
    if (head.main_sel != MAIN_NONE) begin
      for (int i = 0; i < 4; i++) begin
        if (3'(i) < mn_e.len) begin
          lst_byte[k] = mn_e.b[i];
          k = k + 3'd1;
        end
      end
    end
    if (head.tail_sel == TAIL_DONE) begin
      lst_kind[k] = KIND_DONE;
      k = k + 3'd1;
    end else if (head.tail_sel == TAIL_ERR) begin
      lst_kind[k] = KIND_ERR;
      lst_err[k]  = head.err;
      k = k + 3'd1;
    end
    n = k;
  end

  assign out_free = !out_valid_r || out_ready;
  assign last_ent = (idx_r == n - 3'd1);
  assign q_pop    = out_free && !q_empty && last_ent;

  always_comb begin
    out_valid_nxt = out_valid_r;
    byte_nxt      = byte_r;
    kind_nxt      = kind_r;
    err_nxt       = err_r;
    last_nxt      = last_r;
    idx_nxt       = idx_r;
    if (out_free) begin
      out_valid_nxt = !q_empty;
      if (!q_empty) begin
        byte_nxt = lst_byte[idx_r];
        kind_nxt = lst_kind[idx_r];
        err_nxt  = lst_err[idx_r];
        last_nxt = last_ent;
        idx_nxt  = last_ent ? 3'd0 : idx_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    kind_r <= kind_nxt;
    err_r  <= err_nxt;
    last_r <= last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_byte       = byte_r;
  assign out_kind       = kind_r;
  assign out_error_code = err_r;
  assign out_last       = last_r;

endmodule
`default_nettype wire

// ----- rtl/jsu_checker.sv -----
`default_nettype none
module jsu_checker (
  input wire       clk,
  input wire       rst_n,
  input wire       out_valid,
  input wire       out_ready,
  input wire [7:0] out_byte,
  input wire [1:0] out_kind,
  input wire [2:0] out_error_code,
  input wire       out_last
);
  import jsu_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_kind)
      && $stable(out_error_code) && $stable(out_last))
    else $error("output changed while stalled");

  // done and error always close the results of their byte
  a_marker_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_DONE || out_kind == KIND_ERR) |-> out_last)
    else $error("done/error not marked last");

  a_marker_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_DATA |-> out_byte == 8'd0)
    else $error("marker carries a data byte");

  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_kind == KIND_ERR) ? (out_error_code <= ERR_UNTERM)
                                         : (out_error_code == 3'd0))
    else $error("bad error code");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind json_string_unescape_utf8 jsu_checker u_jsu_checker (.*);
`default_nettype wire

// ----- tb/tb_json_string_unescape_utf8.sv -----
module tb_json_string_unescape_utf8;
  import jsu_pkg::*;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [2:0] NO_ERR    = 3'd0;
  localparam logic [7:0] SHORT_ESC [8] = '{CH_QUOTE, CH_BSLASH, "/", "b", "f", "n", "r", "t"};
  localparam int TARGET_BYTES = 270;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] kind;
    logic [2:0] err;
    logic       last;
  } result_t;

  typedef struct packed {
    logic [7:0] b;
    logic       eot;
    logic       typed;
    result_t    want;
  } row_t;

  localparam result_t NOTHING = '0;

  // directed bytes; typed rows carry the single result they must give
  localparam row_t DIR_ROWS [28] = '{
    '{"x",       1'b0, 1'b1, '{8'h00, KIND_ERR,  ERR_NO_QUOTE, 1'b1}},
    '{CH_QUOTE,  1'b0, 1'b0, NOTHING},
    '{8'h00,     1'b0, 1'b1, '{8'h00, KIND_DATA, NO_ERR,       1'b1}},
    '{8'hFF,     1'b0, 1'b1, '{8'hFF, KIND_DATA, NO_ERR,       1'b1}},
    '{CH_BSLASH, 1'b0, 1'b0, NOTHING},
    '{"q",       1'b0, 1'b1, '{8'h00, KIND_ERR,  ERR_UNKNOWN,  1'b1}},
    '{CH_QUOTE,  1'b0, 1'b0, NOTHING},
    '{CH_BSLASH, 1'b0, 1'b0, NOTHING},
    '{CH_U,      1'b0, 1'b0, NOTHING},
    '{"D",       1'b0, 1'b0, NOTHING},
    '{"b",       1'b0, 1'b0, NOTHING},
    '{"F",       1'b0, 1'b0, NOTHING},
    '{"f",       1'b0, 1'b0, NOTHING},
    '{CH_BSLASH, 1'b0, 1'b0, NOTHING},
    '{CH_U,      1'b0, 1'b0, NOTHING},
    '{"d",       1'b0, 1'b0, NOTHING},
    '{"F",       1'b0, 1'b0, NOTHING},
    '{"f",       1'b0, 1'b0, NOTHING},
    '{"F",       1'b0, 1'b0, NOTHING},
    '{CH_QUOTE,  1'b0, 1'b1, '{8'h00, KIND_DONE, NO_ERR,       1'b1}},
    '{CH_QUOTE,  1'b0, 1'b0, NOTHING},
    '{"A",       1'b1, 1'b0, NOTHING},
    '{CH_QUOTE,  1'b0, 1'b0, NOTHING},
    '{CH_BSLASH, 1'b1, 1'b1, '{8'h00, KIND_ERR,  ERR_TRUNC,    1'b1}},
    '{CH_QUOTE,  1'b0, 1'b0, NOTHING},
    '{CH_BSLASH, 1'b0, 1'b0, NOTHING},
    '{CH_U,      1'b0, 1'b0, NOTHING},
    '{"g",       1'b0, 1'b1, '{8'h00, KIND_ERR,  ERR_BAD_HEX,  1'b1}}
  };

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte = 8'h00;
  logic       in_last_of_text = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic [1:0] out_kind;
  logic [2:0] out_error_code;
  logic       out_last;

  json_string_unescape_utf8 uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_byte(in_byte),
    .in_last_of_text(in_last_of_text),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_byte(out_byte),
    .out_kind(out_kind),
    .out_error_code(out_error_code),
    .out_last(out_last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor: parser state and the results one byte gives
  // ---------------------------------------------------------------------------
  typedef enum logic [2:0] {
    P_WAIT, P_TEXT, P_ESC, P_HEX, P_AFTER_HI, P_HI_BS, P_HI_U
  } parse_t;

  parse_t      pmode;
  logic [15:0] acc;
  logic [2:0]  ndig;
  logic [9:0]  hi_part;
  result_t     step_out[$];
  result_t     decoded_q[$];

  int mismatches = 0;
  int sent = 0;
  int n_data = 0;
  int n_done = 0;
  int n_err = 0;
  bit calm = 1'b0;

  function automatic int hex_val(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  function automatic void put(input logic [7:0] d, input logic [1:0] k, input logic [2:0] e);
    result_t r;
    r.data = d;
    r.kind = k;
    r.err  = e;
    r.last = 1'b0;
    step_out.insert(step_out.size(), r);
  endfunction

  function automatic void put_err(input logic [2:0] e);
    put(8'h00, KIND_ERR, e);
    pmode = P_WAIT;
  endfunction

  function automatic void put_cp(input logic [20:0] cp);
    if (cp < 21'h80) begin
      put(cp[7:0], KIND_DATA, NO_ERR);
    end else if (cp < 21'h800) begin
      put({3'b110, cp[10:6]}, KIND_DATA, NO_ERR);
      put({2'b10, cp[5:0]}, KIND_DATA, NO_ERR);
    end else if (cp < 21'h10000) begin
      put({4'b1110, cp[15:12]}, KIND_DATA, NO_ERR);
      put({2'b10, cp[11:6]}, KIND_DATA, NO_ERR);
      put({2'b10, cp[5:0]}, KIND_DATA, NO_ERR);
    end else begin
      put({5'b11110, cp[20:18]}, KIND_DATA, NO_ERR);
      put({2'b10, cp[17:12]}, KIND_DATA, NO_ERR);
      put({2'b10, cp[11:6]}, KIND_DATA, NO_ERR);
      put({2'b10, cp[5:0]}, KIND_DATA, NO_ERR);
    end
  endfunction

  // flush a waiting high surrogate as a lone three-byte sequence
  function automatic void put_high();
    put_cp({5'b0, 6'b110110, hi_part});
  endfunction

  function automatic void str_byte(input logic [7:0] c, input logic eot);
    pmode = P_TEXT;
    if (c == CH_QUOTE) begin
      put(8'h00, KIND_DONE, NO_ERR);
      pmode = P_WAIT;
    end else if (c == CH_BSLASH) begin
      if (eot) put_err(ERR_TRUNC);
      else pmode = P_ESC;
    end else begin
      put(c, KIND_DATA, NO_ERR);
      if (eot) put_err(ERR_UNTERM);
    end
  endfunction

  function automatic void esc_byte(input logic [7:0] c, input logic eot);
    logic [7:0] b;
    logic known;
    b = c;
    known = 1'b1;
    case (c)
      CH_QUOTE, CH_BSLASH, "/": b = c;
      "b": b = 8'h08;
      "f": b = 8'h0C;
      "n": b = 8'h0A;
      "r": b = 8'h0D;
      "t": b = 8'h09;
      default: known = 1'b0;
    endcase
    if (c == CH_U) begin
      if (eot) begin
        put_err(ERR_BAD_HEX);
      end else begin
        pmode = P_HEX;
        acc = '0;
        ndig = '0;
      end
    end else if (!known) begin
      put_err(ERR_UNKNOWN);
    end else begin
      put(b, KIND_DATA, NO_ERR);
      pmode = P_TEXT;
      if (eot) put_err(ERR_UNTERM);
    end
  endfunction

  function automatic void hex_done(input logic eot);
    if (ndig >= 3'd4) begin
      if (acc >= 16'hD800 && acc <= 16'hDBFF) begin
        hi_part = acc[9:0];
        pmode = P_AFTER_HI;
        if (eot) begin
          put_high();
          put_err(ERR_UNTERM);
        end
      end else begin
        put_cp({5'b0, acc});
        pmode = P_TEXT;
        if (eot) put_err(ERR_UNTERM);
      end
    end else if (eot) begin
      put_err(ERR_BAD_HEX);
    end
  endfunction

  function automatic void push_digit(input int v);
    acc = {acc[11:0], 4'(v)};
    ndig = ndig + 3'd1;
  endfunction

  function automatic void unescape_byte(input logic [7:0] c, input logic eot);
    int v;
    step_out.delete();
    case (pmode)
      P_TEXT: str_byte(c, eot);
      P_ESC:  esc_byte(c, eot);
      P_HEX: begin
        v = hex_val(c);
        if (v < 0) begin
          put_err(ERR_BAD_HEX);
        end else begin
          push_digit(v);
          hex_done(eot);
        end
      end
      P_AFTER_HI: begin
        if (c == CH_BSLASH && !eot) begin
          pmode = P_HI_BS;
        end else begin
          put_high();
          str_byte(c, eot);
        end
      end
      P_HI_BS: begin
        if (c == CH_U && !eot) begin
          pmode = P_HI_U;
          acc = '0;
          ndig = '0;
        end else begin
          put_high();
          esc_byte(c, eot);
        end
      end
      P_HI_U: begin
        v = hex_val(c);
        if (v < 0) begin
          put_high();
          put_err(ERR_BAD_HEX);
        end else begin
          push_digit(v);
          // not a low surrogate after all: flush the high one, go on as plain \u
          if ((ndig == 3'd1 && v != 'hD) || (ndig == 3'd2 && v < 'hC)) begin
            put_high();
            pmode = P_HEX;
            hex_done(eot);
          end else if (ndig >= 3'd4) begin
            put_cp(21'h10000 + {1'b0, hi_part, acc[9:0]});
            pmode = P_TEXT;
            if (eot) put_err(ERR_UNTERM);
          end else if (eot) begin
            put_high();
            put_err(ERR_BAD_HEX);
          end
        end
      end
      default: begin
        pmode = P_WAIT;
        if (c == CH_QUOTE) begin
          pmode = P_TEXT;
          if (eot) put_err(ERR_UNTERM);
        end else begin
          put_err(ERR_NO_QUOTE);
        end
      end
    endcase
    if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Random text generation
  // ---------------------------------------------------------------------------
  logic [7:0] txt_b[$];
  bit         txt_l[$];

  function automatic void add_byte(input logic [7:0] b);
    txt_b.insert(txt_b.size(), b);
    txt_l.insert(txt_l.size(), 1'b0);
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) return "0" + v;
    return ($urandom_range(1) ? "A" : "a") + v - 8'd10;
  endfunction

  function automatic void add_hex4(input logic [15:0] v);
    for (int i = 3; i >= 0; i--) add_byte(hex_char(v[4*i +: 4]));
  endfunction

  function automatic void add_uesc(input logic [15:0] v);
    add_byte(CH_BSLASH);
    add_byte(CH_U);
    add_hex4(v);
  endfunction

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do begin
      b = ($urandom_range(99) < 70) ? 8'($urandom_range(126, 32)) : 8'($urandom_range(255));
    end while (b == CH_QUOTE || b == CH_BSLASH);
    return b;
  endfunction

  function automatic logic [15:0] high_surr();
    return 16'($urandom_range(16'hDBFF, 16'hD800));
  endfunction

  task automatic build_text();
    int ntok, p, k;
    logic [15:0] cp;
    logic [7:0] b, bad;
    bit stop, known;
    txt_b.delete();
    txt_l.delete();
    stop = 1'b0;
    if ($urandom_range(99) < 15) begin
      do b = 8'($urandom_range(255)); while (b == CH_QUOTE);
      add_byte(b);
    end
    add_byte(CH_QUOTE);
    ntok = $urandom_range(6);
    for (int t = 0; t < ntok && !stop; t++) begin
      k = $urandom_range(99);
      if (k < 35) begin
        add_byte(plain_byte());
      end else if (k < 50) begin
        add_byte(CH_BSLASH);
        add_byte(SHORT_ESC[$urandom_range(7)]);
      end else if (k < 70) begin
        case ($urandom_range(4))
          0: cp = 16'($urandom_range(16'h7F));
          1: cp = 16'($urandom_range(16'h7FF, 16'h80));
          2: cp = $urandom_range(1) ? 16'($urandom_range(16'hD7FF, 16'h800))
                                    : 16'($urandom_range(16'hFFFF, 16'hE000));
          3: cp = 16'($urandom_range(16'hDFFF, 16'hDC00));
          default: cp = high_surr();
        endcase
        add_uesc(cp);
      end else if (k < 85) begin
        add_uesc(high_surr());
        add_uesc(16'($urandom_range(16'hDFFF, 16'hDC00)));
      end else if (k < 93) begin
        // high surrogate followed by something other than a low one
        add_uesc(high_surr());
        case ($urandom_range(3))
          0: add_byte(plain_byte());
          1: begin
            add_byte(CH_BSLASH);
            add_byte(SHORT_ESC[$urandom_range(7)]);
          end
          2: begin
            do cp = 16'($urandom_range(16'hFFFF)); while (cp[15:12] == 4'hD);
            add_uesc(cp);
          end
          default: begin
            add_byte(CH_BSLASH);
            add_byte(CH_U);
            add_byte(hex_char(4'hD));
            add_byte(hex_char(4'($urandom_range(11))));
            add_byte(hex_char(4'($urandom_range(15))));
            add_byte(hex_char(4'($urandom_range(15))));
          end
        endcase
      end else begin
        // broken escapes; the string ends in an error here
        stop = 1'b1;
        do bad = 8'($urandom_range(255)); while (hex_val(bad) >= 0);
        case ($urandom_range(2))
          0: begin
            do begin
              b = 8'($urandom_range(255));
              known = (b == CH_U);
              for (int i = 0; i < 8; i++) if (b == SHORT_ESC[i]) known = 1'b1;
            end while (known);
            add_byte(CH_BSLASH);
            add_byte(b);
          end
          1: begin
            add_byte(CH_BSLASH);
            add_byte(CH_U);
            repeat ($urandom_range(3)) add_byte(hex_char(4'($urandom_range(15))));
            add_byte(bad);
          end
          default: begin
            add_uesc(high_surr());
            add_byte(CH_BSLASH);
            add_byte(CH_U);
            add_byte(hex_char(4'hD));
            if ($urandom_range(1)) add_byte(hex_char(4'($urandom_range(15, 12))));
            add_byte(bad);
          end
        endcase
      end
    end
    if (!stop && $urandom_range(99) < 85) add_byte(CH_QUOTE);
    // end of text at a random point, or right at the end, or not at all
    if ($urandom_range(99) < 25) begin
      p = $urandom_range(txt_b.size() - 1);
      while (txt_b.size() > p + 1) begin
        void'(txt_b.pop_back());
        void'(txt_l.pop_back());
      end
      txt_l[p] = 1'b1;
    end else if ($urandom_range(1)) begin
      txt_l[txt_b.size() - 1] = 1'b1;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------
  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send_byte(input logic [7:0] b, input logic eot, input row_t row);
    while (!calm && $urandom_range(99) < 11) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    in_last_of_text <= eot;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    unescape_byte(b, eot);
    if (row.typed) begin
      step_out.delete();
      step_out.insert(0, row.want);
    end
    foreach (step_out[i]) decoded_q.insert(decoded_q.size(), step_out[i]);
    sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (decoded_q.size() != 0);
  endtask

  always @(negedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= 11);
  end

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 40) $display("ERROR @%0t: %s", $time, msg);
  endtask

  result_t got, head;

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      got = {out_byte, out_kind, out_error_code, out_last};
      case (out_kind)
        KIND_DATA: n_data++;
        KIND_DONE: n_done++;
        default:   n_err++;
      endcase
      if (decoded_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result byte %02h kind %0d err %0d last %0d",
                                  got.data, got.kind, got.err, got.last));
      end else begin
        head = decoded_q.pop_front();
        if (got.data !== head.data || got.kind !== head.kind || got.err !== head.err ||
            got.last !== head.last)
          report_mismatch($sformatf(
            "got byte %02h kind %0d err %0d last %0d, want byte %02h kind %0d err %0d last %0d",
            got.data, got.kind, got.err, got.last,
            head.data, head.kind, head.err, head.last));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    bit paused;
    paused = 1'b0;
    pmode = P_WAIT;
    acc = '0;
    ndig = '0;
    hi_part = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (DIR_ROWS[i]) send_byte(DIR_ROWS[i].b, DIR_ROWS[i].eot, DIR_ROWS[i]);
    wait_drained();

    while (sent < TARGET_BYTES) begin
      build_text();
      foreach (txt_b[i]) begin
        calm = (sent >= 180 && sent < 240);
        send_byte(txt_b[i], txt_l[i], NOTHING);
      end
      if (!paused && sent >= 150) begin
        paused = 1'b1;
        wait_drained();
      end
    end
    calm = 1'b0;

    wait_drained();
    repeat (10) @(negedge clk);

    $display("Sent %0d bytes (%0d directed, rest random strings with escapes and surrogates)",
             sent, $size(DIR_ROWS));
    $display("Checked %0d results: %0d data bytes, %0d strings closed, %0d errors",
             n_data + n_done + n_err, n_data, n_done, n_err);
    if (mismatches == 0 && decoded_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("Timeout with %0d results outstanding", decoded_q.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/jsu_pkg.sv
rtl/jsu_front.sv
rtl/jsu_fifo.sv
rtl/jsu_back.sv
rtl/json_string_unescape_utf8.sv
rtl/jsu_checker.sv
tb/tb_json_string_unescape_utf8.sv
